// ----- rtl/dqhr_pkg.sv -----
// shared constants, types and index arithmetic for the half-rotate deque
package dqhr_pkg;

   localparam int CAPACITY = 1024;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 11;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_POP_FRONT  = 3'd1,
      MODE_PUSH_BACK  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_ROTATE     = 3'd4
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                     wr_en;
      logic                     rd_en;
      logic [IDX_W-1:0]         addr;
      logic signed [DATA_W-1:0] wr_data;
   } ring_cmd_type;

   // ring position of base plus offset, offset below the capacity
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] offset);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, offset};
      if (sum >= (CNT_W + 1)'(CAPACITY)) begin
         sum = sum - (CNT_W + 1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ----- rtl/dqhr_ifs.sv -----
// command and response channel interfaces
interface dqhr_req_if import dqhr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [DATA_W-1:0] push_value;

   modport source (output valid, mode, push_value, input ready);
   modport sink   (input valid, mode, push_value, output ready);
endinterface

interface dqhr_rsp_if import dqhr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] pop_value;
   logic [STATUS_W-1:0]      status;
   logic [FILL_W-1:0]        fill_count;

   modport source (output valid, pop_value, status, fill_count, input ready);
   modport sink   (input valid, pop_value, status, fill_count, output ready);
endinterface

// ----- rtl/dqhr_ring.sv -----
// single-port ring store with registered read data
module dqhr_ring import dqhr_pkg::*; (
   input  logic                     clock,
   input  ring_cmd_type             cmd,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] mem [CAPACITY];
   logic signed [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/deque_with_half_rotate.sv -----
// top level: deque controller, read stage and response register
// Double-ended queue of signed 32-bit words in a 1024-entry ring store. Commands push or pop
// at either end, or rotate so that the element at position floor(count/2) becomes the front.
// One command is taken per cycle when the response side keeps up; its response is held in
// the read stage, which takes the ring store's registered read data, and then in the
// response register. Front index and count are updated at acceptance, so a pop right after
// a push to the same entry reads the new word without extra forwarding. A pop on an empty
// queue reports status 1, a push on a full queue is dropped with status 2; every response
// carries the fill count after its command.
module deque_with_half_rotate import dqhr_pkg::*; (
   input logic       clock,
   input logic       reset,
   dqhr_req_if.sink   req_ch,
   dqhr_rsp_if.source rsp_ch
);

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_pop_ff;
   status_type       s1_status_ff;
   logic [CNT_W-1:0] s1_count_ff;

   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_pop_ff;
   status_type               out_status_ff;
   logic [FILL_W-1:0]        out_fill_ff;

   logic                     accept, out_free, advance;
   logic                     full, empty, is_pop;
   status_type               status;
   ring_cmd_type             ring_cmd;
   logic signed [DATA_W-1:0] rd_data;

   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign advance  = s1_valid_ff && out_free;
   assign req_ch.ready = !reset && (!s1_valid_ff || out_free);
   assign accept   = req_ch.valid && req_ch.ready;

   always_comb begin
      front_in         = front_ff;
      count_in         = count_ff;
      status           = STATUS_OK;
      is_pop           = 1'b0;
      ring_cmd.wr_en   = 1'b0;
      ring_cmd.rd_en   = 1'b0;
      ring_cmd.addr    = front_ff;
      ring_cmd.wr_data = req_ch.push_value;
      if (accept) begin
         unique case (mode_type'(req_ch.mode))
            MODE_PUSH_FRONT: begin
               if (full) begin
                  status = STATUS_FULL;
               end else begin
                  front_in       = ring_add(front_ff, CNT_W'(CAPACITY - 1));
                  ring_cmd.addr  = front_in;
                  ring_cmd.wr_en = 1'b1;
                  count_in       = count_ff + 1'b1;
               end
            end
            MODE_POP_FRONT: begin
               if (empty) begin
                  status = STATUS_EMPTY;
               end else begin
                  is_pop         = 1'b1;
                  ring_cmd.rd_en = 1'b1;
                  front_in       = ring_add(front_ff, CNT_W'(1));
                  count_in       = count_ff - 1'b1;
               end
            end
            MODE_PUSH_BACK: begin
               if (full) begin
                  status = STATUS_FULL;
               end else begin
                  ring_cmd.addr  = ring_add(front_ff, count_ff);
                  ring_cmd.wr_en = 1'b1;
                  count_in       = count_ff + 1'b1;
               end
            end
            MODE_POP_BACK: begin
               if (empty) begin
                  status = STATUS_EMPTY;
               end else begin
                  is_pop         = 1'b1;
                  ring_cmd.rd_en = 1'b1;
                  ring_cmd.addr  = ring_add(front_ff, count_ff - 1'b1);
                  count_in       = count_ff - 1'b1;
               end
            end
            MODE_ROTATE: begin
               if (count_ff > CNT_W'(1)) begin
                  front_in = ring_add(front_ff, count_ff >> 1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   dqhr_ring u_ring (
      .clock   (clock),
      .cmd     (ring_cmd),
      .rd_data (rd_data)
   );

   always_comb begin
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pop_ff    <= is_pop;
         s1_status_ff <= status;
         s1_count_ff  <= count_in;
      end
      if (advance) begin
         out_pop_ff    <= s1_pop_ff ? rd_data : '0;
         out_status_ff <= s1_status_ff;
         out_fill_ff   <= FILL_W'(s1_count_ff);
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.pop_value  = out_pop_ff;
   assign rsp_ch.status     = out_status_ff;
   assign rsp_ch.fill_count = out_fill_ff;

   // count stays within the ring
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("element count beyond capacity");

   // a held read stage blocks new commands
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |-> !req_ch.ready)
      else $error("command taken while read stage is stalled");

   // failed pops return zero
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff == STATUS_EMPTY) |-> (out_pop_ff == '0))
      else $error("non-zero word on pop from empty queue");

   // a successful push grows the count by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (accept && !full && (req_ch.mode == MODE_PUSH_FRONT || req_ch.mode == MODE_PUSH_BACK))
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not advance the count");

endmodule
